>>> src/shs_pkg.sv
`default_nettype none

package shs_pkg;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_FINAL  = 5'b01000,
        ST_DIGEST = 5'b10000
    } shs_state_t;

    typedef logic [31:0] shs_word_t;

    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_START  = 6'd56;
    localparam logic [5:0]  FILL_LAST  = 6'd63;
    localparam logic [5:0]  ROUND_LAST = 6'd63;
    localparam logic [2:0]  WORD_LAST  = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    function automatic shs_word_t ror32(input shs_word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    // Initial chaining values
    function automatic shs_word_t init_word(input logic [2:0] idx);
        case (idx)
            3'd0:    init_word = 32'h6a09e667;
            3'd1:    init_word = 32'hbb67ae85;
            3'd2:    init_word = 32'h3c6ef372;
            3'd3:    init_word = 32'ha54ff53a;
            3'd4:    init_word = 32'h510e527f;
            3'd5:    init_word = 32'h9b05688c;
            3'd6:    init_word = 32'h1f83d9ab;
            default: init_word = 32'h5be0cd19;
        endcase
    endfunction

    // Round constants
    function automatic shs_word_t round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> src/sha256_stream_hasher.sv
// SHA-256 hasher, one message byte per input request.
// A byte that does not complete a block does not hold the input; one that completes a block
// holds it while the block runs 64 rounds on one shared round unit, then the hash add.
// End of message: pad to the block end and compress (two blocks when fill >= 56),
// then eight digest words, one per accepted output request.
// Reset (asynchronous, rst_n low) loads the initial hash values and clears fill and length.
`default_nettype none

module sha256_stream_hasher
    import shs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast,   // last_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    shs_state_t  state_reg, state_next;
    shs_word_t   hash_reg [NUM_WORDS];
    shs_word_t   hash_next [NUM_WORDS];
    shs_word_t   work_reg [NUM_WORDS];
    shs_word_t   work_next [NUM_WORDS];
    logic [511:0] blk_reg, blk_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        lenph_reg, lenph_next;

    logic        in_fire, out_fire;
    logic        shift_en;
    logic [7:0]  shift_byte;
    shs_word_t   w_cur, w_new;
    shs_word_t   s0_sched, s1_sched;
    shs_word_t   sum1, sum0, ch, maj, t1, t2;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_DIGEST);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = hash_reg[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == WORD_LAST);

    // Message schedule: the block register doubles as the 16-word window
    assign w_cur    = blk_reg[511:480];
    assign s0_sched = ror32(blk_reg[479:448], 7) ^ ror32(blk_reg[479:448], 18)
                    ^ (blk_reg[479:448] >> 3);
    assign s1_sched = ror32(blk_reg[63:32], 17) ^ ror32(blk_reg[63:32], 19)
                    ^ (blk_reg[63:32] >> 10);
    assign w_new    = s1_sched + blk_reg[223:192] + s0_sched + w_cur;

    // Shared round unit
    assign sum1 = ror32(work_reg[4], 6) ^ ror32(work_reg[4], 11) ^ ror32(work_reg[4], 25);
    assign ch   = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign t1   = work_reg[7] + sum1 + ch + round_k(rnd_reg) + w_cur;
    assign sum0 = ror32(work_reg[0], 2) ^ ror32(work_reg[0], 13) ^ ror32(work_reg[0], 22);
    assign maj  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                ^ (work_reg[1] & work_reg[2]);
    assign t2   = sum0 + maj;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        blk_next   = blk_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        lenph_next = lenph_reg;
        shift_en   = 1'b0;
        shift_byte = s_axis_tdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pad_next = s_axis_tlast;
                    if (s_axis_tuser)
                    begin
                        shift_en = 1'b1;
                        len_next = len_reg + BITS_PER_BYTE;
                    end
                    if (s_axis_tuser && (fill_reg == FILL_LAST))
                    begin
                        state_next = ST_ROUND;
                        work_next  = hash_reg;
                        rnd_next   = '0;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                // Append marker, zeros, then the bit length, most significant byte first
                shift_en = 1'b1;
                if (!mark_reg)
                begin
                    shift_byte = PAD_MARK;
                    mark_next  = 1'b1;
                end
                else if (lenph_reg || (fill_reg == LEN_START))
                begin
                    shift_byte = len_reg[63:56];
                    lenph_next = 1'b1;
                    len_next   = {len_reg[55:0], 8'h00};
                end
                else
                begin
                    shift_byte = 8'h00;
                end
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    work_next  = hash_reg;
                    rnd_next   = '0;
                end
            end

            ST_ROUND:
            begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                blk_next     = {blk_reg[479:0], w_new};
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                if (lenph_reg)
                begin
                    state_next = ST_DIGEST;
                    idx_next   = '0;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DIGEST:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == WORD_LAST)
                    begin
                        // Return to the initial state for the next message
                        for (int i = 0; i < NUM_WORDS; i++)
                        begin
                            hash_next[i] = init_word(i[2:0]);
                        end
                        len_next   = '0;
                        fill_next  = '0;
                        pad_next   = 1'b0;
                        mark_next  = 1'b0;
                        lenph_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Shift one byte into the block register
        if (shift_en)
        begin
            blk_next  = {blk_reg[503:0], shift_byte};
            fill_next = fill_reg + 6'd1;
        end
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                hash_reg[i] <= init_word(i[2:0]);
            end
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            lenph_reg <= lenph_next;
        end
    end

    // Block and working variables
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

endmodule

`default_nettype wire

>>> tb/sha256_digest_checker.sv
`timescale 1ns / 100ps

module sha256_digest_checker
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  shs_word_t   m_axis_tdata,   // [31:0] digest_word
    input  logic [2:0]  m_axis_tuser,   // [2:0] word_index
    input  logic        m_axis_tlast,   // last_word
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output int          words_due,
    output int          mismatches
);

    typedef struct packed {
        shs_word_t  word;
        logic [2:0] idx;
        logic       last;
    } digest_word_t;

    // Chaining values, first word in the top bits
    localparam logic [255:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants, round 0 in the top bits
    localparam logic [2047:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] END_MARK     = 8'h80;
    localparam logic [5:0] LENGTH_SLOT  = 6'd56;

    shs_word_t    chain [8];
    logic [7:0]   block [64];
    logic [5:0]   fill;
    logic [63:0]  bits_done;
    digest_word_t digest_q [$];

    initial mismatches = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    function automatic shs_word_t rotr(input shs_word_t x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // Load fresh chaining values and an empty length count
    task automatic restart_message();
        int i;
        for (i = 0; i < 8; i++)
            chain[i] = START_HASH[(7 - i) * 32 +: 32];
        fill = '0;
        bits_done = '0;
    endtask

    // Fold the current block into the chaining values
    task automatic compress_block();
        shs_word_t sched [64];
        shs_word_t v [8];
        shs_word_t s0, s1, t1, t2;
        int i;
        for (i = 0; i < 16; i++)
            sched[i] = {block[4 * i], block[4 * i + 1], block[4 * i + 2], block[4 * i + 3]};
        for (i = 16; i < 64; i++) begin
            s0 = rotr(sched[i - 15], 7) ^ rotr(sched[i - 15], 18) ^ (sched[i - 15] >> 3);
            s1 = rotr(sched[i - 2], 17) ^ rotr(sched[i - 2], 19) ^ (sched[i - 2] >> 10);
            sched[i] = s1 + sched[i - 7] + s0 + sched[i - 16];
        end
        for (i = 0; i < 8; i++)
            v[i] = chain[i];
        for (i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[(63 - i) * 32 +: 32]
                 + sched[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    // Take one input request; on end of message pad, finish and queue the digest
    task automatic absorb_item(input logic [7:0] data, input logic has_byte, input logic eom);
        logic [63:0] length;
        digest_word_t w;
        int i;
        if (has_byte) begin
            block[fill] = data;
            fill = fill + 6'd1;
            if (fill == '0) begin
                compress_block();
                bits_done = bits_done + 64'd512;
            end
        end
        if (eom) begin
            block[fill] = END_MARK;
            for (i = int'(fill) + 1; i < 64; i++)
                block[i] = '0;
            // no room for the length: spill into a second block
            if (fill >= LENGTH_SLOT) begin
                compress_block();
                for (i = 0; i < 56; i++)
                    block[i] = '0;
            end
            length = bits_done + {55'd0, fill, 3'd0};
            for (i = 0; i < 8; i++)
                block[56 + i] = length[63 - 8 * i -: 8];
            compress_block();
            for (i = 0; i < 8; i++) begin
                w.word = chain[i];
                w.idx  = 3'(i);
                w.last = (i == 7);
                digest_q.push_back(w);
            end
            restart_message();
        end
    endtask

    // Compare one output request with the oldest digest word
    task automatic check_word();
        digest_word_t want;
        if (digest_q.size() == 0) begin
            report("unexpected digest word", m_axis_tdata, '0);
        end else begin
            want = digest_q.pop_front();
            if (m_axis_tdata !== want.word)
                report("digest_word", m_axis_tdata, want.word);
            if (m_axis_tuser !== want.idx)
                report("word_index", {29'd0, m_axis_tuser}, {29'd0, want.idx});
            if (m_axis_tlast !== want.last)
                report("last_word", {31'd0, m_axis_tlast}, {31'd0, want.last});
        end
    endtask

    // Watch both channels; publish the backlog through a register
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restart_message();
            digest_q.delete();
            words_due <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready)
                absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            words_due <= digest_q.size();
        end
    end

endmodule

>>> tb/sha256_stream_hasher_test.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_test
    import shs_pkg::*;
();

    localparam int ITEM_TARGET = 400;
    localparam int CALM_AFTER  = 340;
    localparam int STUCK_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       s_axis_tuser;   // [0] has_byte
    logic       s_axis_tlast;   // end_of_message
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    shs_word_t  m_axis_tdata;   // [31:0] digest_word
    logic [2:0] m_axis_tuser;   // [2:0] word_index
    logic       m_axis_tlast;   // last_word
    logic       m_axis_tvalid;
    logic       m_axis_tready;

    int words_due;
    int mismatches;
    int items_sent = 0;
    int stuck_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit sender_calm = 1'b0;

    sha256_stream_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    sha256_digest_checker hash_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .words_due     (words_due),
        .mismatches    (mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the digest side in short bursts, never once the tail is reached
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                m_axis_tready <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        else
        begin
            stuck_cycles <= 0;
        end
    end

    // Present one input request and hold it until taken
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
        int gap;
        if (!sender_calm && !calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= eom;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (has_byte || eom)
            items_sent++;
    endtask

    // Send a message of random bytes, with empty requests mixed in
    task automatic send_message(input int len, input bit eom_on_byte);
        int k;
        sender_calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
        begin
            if (!calm && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (k == len - 1));
        end
        if (!eom_on_byte || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        int pick;
        int boundary_len [4];
        int m;
        boundary_len = '{55, 56, 63, 64};

        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored empty request, then the empty message
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // one zero byte ending its own message
        send_item(8'h00, 1'b1, 1'b1);
        // all-ones byte, filler, then an end request without a byte
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        // "abc"
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // two empty messages back to back
        send_item(8'h33, 1'b0, 1'b1);
        send_item(8'hcc, 1'b0, 1'b1);

        // hold off until every digest word is back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);

        // lengths around the padding and block boundaries
        for (m = 0; m < 4; m++)
            send_message(boundary_len[m], 1'($urandom_range(0, 1)));

        // random messages, quiet toward the end
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                len = $urandom_range(0, 3);
            else if (pick == 1)
                len = $urandom_range(52, 66);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(110, 135);
            else
                len = $urandom_range(4, 48);
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
            send_message(len, 1'($urandom_range(0, 1)));
        end

        // drain the last digest, then a settling wait
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
src/shs_pkg.sv
src/sha256_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/sha256_stream_hasher_test.sv
